// ===== hdl/a85_pkg.sv =====
package a85_pkg;

  // Line length default and the width of the group counter on a line.
  localparam int unsigned GroupsPerLineDflt = 16;
  localparam int unsigned LineW = 4;

  // Number of register stages in the base-85 digit pipeline.
  localparam int unsigned Stages = 5;

  localparam logic [6:0] DigitBase = 7'h21; // '!'
  localparam logic [6:0] CharZ     = 7'h7A; // 'z'
  localparam logic [6:0] CharNl    = 7'h0A;
  localparam logic [6:0] CharTilde = 7'h7E; // '~'
  localparam logic [6:0] CharGt    = 7'h3E; // '>'

  typedef enum logic {
    KIND_DATA  = 1'b0,
    KIND_CLOSE = 1'b1
  } kind_e;

  // What a job emits: leading digits (or 'z'), then optional newline and "~>".
  typedef struct packed {
    logic [2:0] n_digits;
    logic       zero_grp;
    logic       newline;
    logic       tail;
  } job_meta_t;

  // Base-85 digits, index 0 is the most significant one.
  typedef logic [4:0][6:0] digits_t;

endpackage

// ===== hdl/a85_stream_ifs.sv =====
interface a85_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface a85_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

// ===== hdl/ascii85_stream_encoder_core.sv =====
// ASCII85 stream encoder. Each input transfer is a data byte or a close
// command and is taken whenever the job register has room; a byte that does
// not finish a group only updates the group state. A finished group
// or a close becomes a job that runs through a job register and a five-stage
// pipeline of reciprocal multiplies by 1/85, then leaves through a character
// serializer at one character per cycle while the output is ready. A job
// gives one to six characters, the last one flagged by run_last; the
// serializer sets the sustained rate, with seven jobs buffered in flight.
module ascii85_stream_encoder_core import a85_pkg::*; #(
  parameter int unsigned GroupsPerLine = GroupsPerLineDflt
) (
  input logic      clk_i,
  input logic      rst_ni,
  a85_in_if.sink   in_i,
  a85_out_if.source out_o
);

  localparam int unsigned LimW = LineW + 1;
  localparam logic [LimW-1:0] LineLimit = LimW'(GroupsPerLine);

  logic [7:0]       bytes_q [4];
  logic [1:0]       fill_q;
  logic [LineW-1:0] line_q;

  logic      in_xfer;
  logic      job_gen;
  logic      line_full;
  logic [31:0] job_val;
  job_meta_t job_meta;

  logic        job_vld_q;
  logic [31:0] job_val_q;
  job_meta_t   job_meta_q;

  logic      pipe_ready, pipe_vld, ser_take;
  digits_t   pipe_dig;
  job_meta_t pipe_meta;

  logic      ser_vld_q;
  digits_t   ser_dig_q;
  job_meta_t ser_meta_q;
  logic [2:0] pos_q;

  logic [2:0] n_lead, n_total;
  logic [6:0] digit_sel, char_sel;
  logic       is_last, out_xfer;

  assign in_i.ready = !job_vld_q || pipe_ready;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign line_full  = ({1'b0, line_q} + LimW'(1)) >= LineLimit;

  always_comb begin
    job_gen  = 1'b0;
    job_val  = '0;
    job_meta = '0;
    if (in_i.kind == KIND_DATA) begin
      if (fill_q == 2'd3) begin
        job_gen           = 1'b1;
        job_val           = {bytes_q[0], bytes_q[1], bytes_q[2], in_i.data_byte};
        job_meta.zero_grp = (job_val == 32'd0);
        job_meta.n_digits = job_meta.zero_grp ? 3'd0 : 3'd5;
        job_meta.newline  = line_full;
      end
    end else begin
      job_gen       = 1'b1;
      job_meta.tail = 1'b1;
      case (fill_q)
        2'd1:    job_val = {bytes_q[0], 24'd0};
        2'd2:    job_val = {bytes_q[0], bytes_q[1], 16'd0};
        2'd3:    job_val = {bytes_q[0], bytes_q[1], bytes_q[2], 8'd0};
        default: job_val = '0;
      endcase
      job_meta.n_digits = (fill_q == 2'd0) ? 3'd0 : ({1'b0, fill_q} + 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      line_q <= '0;
    end else if (in_xfer) begin
      if (in_i.kind == KIND_DATA) begin
        fill_q <= fill_q + 2'd1;
        if (fill_q == 2'd3) begin
          line_q <= line_full ? '0 : line_q + LineW'(1);
        end
      end else begin
        fill_q <= '0;
        line_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && in_i.kind == KIND_DATA) begin
      bytes_q[fill_q] <= in_i.data_byte;
    end
  end

  // job register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      job_vld_q <= in_xfer && job_gen;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && job_gen) begin
      job_val_q  <= job_val;
      job_meta_q <= job_meta;
    end
  end

  a85_digit_pipe u_digit_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (job_vld_q),
    .in_ready_o   (pipe_ready),
    .in_value_i   (job_val_q),
    .in_meta_i    (job_meta_q),
    .out_valid_o  (pipe_vld),
    .out_ready_i  (ser_take),
    .out_digits_o (pipe_dig),
    .out_meta_o   (pipe_meta)
  );

  // character serializer
  always_comb begin
    n_lead  = ser_meta_q.zero_grp ? 3'd1 : ser_meta_q.n_digits;
    n_total = n_lead + {2'd0, ser_meta_q.newline} + {1'b0, ser_meta_q.tail, 1'b0};
    case (pos_q)
      3'd0:    digit_sel = ser_dig_q[0];
      3'd1:    digit_sel = ser_dig_q[1];
      3'd2:    digit_sel = ser_dig_q[2];
      3'd3:    digit_sel = ser_dig_q[3];
      3'd4:    digit_sel = ser_dig_q[4];
      default: digit_sel = '0;
    endcase
    if (pos_q < n_lead) begin
      char_sel = ser_meta_q.zero_grp ? CharZ : digit_sel + DigitBase;
    end else if (ser_meta_q.newline && pos_q == n_lead) begin
      char_sel = CharNl;
    end else if (pos_q == n_lead) begin
      char_sel = CharTilde;
    end else begin
      char_sel = CharGt;
    end
    is_last = (pos_q == n_total - 3'd1);
  end

  assign out_o.valid    = ser_vld_q;
  assign out_o.out_char = char_sel;
  assign out_o.run_last = is_last;
  assign out_xfer       = ser_vld_q && out_o.ready;
  assign ser_take       = !ser_vld_q || (out_xfer && is_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
      pos_q     <= '0;
    end else if (ser_take) begin
      ser_vld_q <= pipe_vld;
      pos_q     <= '0;
    end else if (out_xfer) begin
      pos_q <= pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_take) begin
      ser_dig_q  <= pipe_dig;
      ser_meta_q <= pipe_meta;
    end
  end

endmodule

// ===== hdl/a85_digit_pipe.sv =====
module a85_digit_pipe import a85_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [31:0] in_value_i,
  input  job_meta_t in_meta_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output digits_t   out_digits_o,
  output job_meta_t out_meta_o
);

  // floor(x / 85) == (x * ceil(2^38 / 85)) >> 38 for every 32-bit x
  localparam logic [63:0] Recip85 = 64'h0000_0000_C0C0_C0C1;
  localparam int unsigned RecipShift = 38;

  function automatic logic [25:0] div85(input logic [31:0] x);
    logic [63:0] p;
    p = {32'd0, x} * Recip85;
    return p[RecipShift+25:RecipShift];
  endfunction

  function automatic logic [6:0] rem85(input logic [31:0] x, input logic [31:0] q);
    logic [31:0] r;
    r = x - q * 32'd85;
    return r[6:0];
  endfunction

  logic [Stages:0]   adv;
  logic [Stages-1:0] vld_q;
  job_meta_t         meta_q [Stages];

  // stage 1
  logic [31:0] v0_q;
  logic [25:0] q0_q;
  // stage 2
  logic [25:0] q0b_q;
  logic [19:0] q1_q;
  logic [6:0]  d4_2_q;
  // stage 3
  logic [19:0] q1b_q;
  logic [12:0] q2_q;
  logic [6:0]  d4_3_q, d3_3_q;
  // stage 4
  logic [12:0] q2b_q;
  logic [6:0]  q3_q;
  logic [6:0]  d4_4_q, d3_4_q, d2_4_q;
  // stage 5
  digits_t     dig_q;

  logic [25:0] q1_w, q2_w, q3_w;

  always_comb begin
    adv[Stages] = out_ready_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_ready_o   = adv[0];
  assign out_valid_o  = vld_q[Stages-1];
  assign out_digits_o = dig_q;
  assign out_meta_o   = meta_q[Stages-1];

  assign q1_w = div85({6'd0, q0_q});
  assign q2_w = div85({12'd0, q1_q});
  assign q3_w = div85({19'd0, q2_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      meta_q[0] <= in_meta_i;
      v0_q      <= in_value_i;
      q0_q      <= div85(in_value_i);
    end
    if (adv[1]) begin
      meta_q[1] <= meta_q[0];
      q0b_q     <= q0_q;
      q1_q      <= q1_w[19:0];
      d4_2_q    <= rem85(v0_q, {6'd0, q0_q});
    end
    if (adv[2]) begin
      meta_q[2] <= meta_q[1];
      q1b_q     <= q1_q;
      q2_q      <= q2_w[12:0];
      d4_3_q    <= d4_2_q;
      d3_3_q    <= rem85({6'd0, q0b_q}, {12'd0, q1_q});
    end
    if (adv[3]) begin
      meta_q[3] <= meta_q[2];
      q2b_q     <= q2_q;
      q3_q      <= q3_w[6:0];
      d4_4_q    <= d4_3_q;
      d3_4_q    <= d3_3_q;
      d2_4_q    <= rem85({12'd0, q1b_q}, {19'd0, q2_q});
    end
    if (adv[4]) begin
      meta_q[4] <= meta_q[3];
      dig_q[0]  <= q3_q;
      dig_q[1]  <= rem85({19'd0, q2b_q}, {25'd0, q3_q});
      dig_q[2]  <= d2_4_q;
      dig_q[3]  <= d3_4_q;
      dig_q[4]  <= d4_4_q;
    end
  end

endmodule

// ===== hdl/a85_checker.sv =====
module a85_checker import a85_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] out_char_i,
  input logic       run_last_i
);

  logic       out_xfer;
  logic [6:0] last_char_q;

  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_char_q <= '0;
    end else if (out_xfer) begin
      last_char_q <= out_char_i;
    end
  end

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped before transfer");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_char_i) && $stable(run_last_i))
    else $error("output payload changed while stalled");

  a_tilde_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_char_i == CharTilde |-> !run_last_i)
    else $error("'~' flagged as last character");

  // '>' is also a plain digit, so check from the '~' side
  a_gt_after_tilde: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && last_char_q == CharTilde |-> out_char_i == CharGt && run_last_i)
    else $error("'~' not followed by a closing '>'");

endmodule

bind ascii85_stream_encoder_core a85_checker u_a85_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.out_char),
  .run_last_i  (out_o.run_last)
);
